### hdl/smb_pkg.sv
// ----------------------------------------------------------------------------
// smb_pkg: shared definitions of the symmetrized monotone bicubic interpolator
// Holds the fixed-point formats, the window job type and the back-end states.
// ----------------------------------------------------------------------------
package smb_pkg;

  localparam int SAMPLE_BITS = 16;  // raw sample width
  localparam int FRAC_BITS   = 16;  // fractional offset width, Q0.FRAC_BITS
  localparam int W_ONE       = 30;  // weight fraction bits, Q2.30
  localparam int VAL_FRAC    = 16;  // fraction bits of sample values
  localparam int VW          = 48;  // intermediate value width
  localparam int WW          = 32;  // signed weight width
  localparam int Q_DEPTH     = 2;   // window queue depth
  localparam int ROWS        = 4;
  localparam int COLS        = 4;
  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  // One complete 4x4 window with its latched offsets.
  typedef struct packed {
    smp_t [ROWS-1:0][COLS-1:0] smp;
    logic [FRAC_BITS-1:0]      frac_x;
    logic [FRAC_BITS-1:0]      frac_y;
  } job_t;

  // Front to queue.
  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_WX2,
    BK_WX3,
    BK_WY2,
    BK_WY3,
    BK_LOAD,
    BK_LIM,
    BK_SLOPE,
    BK_ABS,
    BK_ML,
    BK_MH,
    BK_STORE,
    BK_FINAL,
    BK_RND,
    BK_OUT
  } bk_state_t;

endpackage

### hdl/smb_front.sv
// ----------------------------------------------------------------------------
// smb_front: row collector
// Accepts row words, keeps rows 0..2 and the offsets, and hands a complete
// window to the queue when the fourth row arrives.
// ----------------------------------------------------------------------------
module smb_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  smb_pkg::smp_t           in_sample_c0,
  input  smb_pkg::smp_t           in_sample_c1,
  input  smb_pkg::smp_t           in_sample_c2,
  input  smb_pkg::smp_t           in_sample_c3,
  input  logic [15:0]             in_frac_x,
  input  logic [15:0]             in_frac_y,
  input  logic                    in_first_row,
  input  logic                    q_full,
  output smb_pkg::push_t          q_push
);
  import smb_pkg::*;

  logic [1:0]           row_count_r, row_count_nxt;
  logic [FRAC_BITS-1:0] held_frac_x_r, held_frac_y_r;
  smp_t [COLS-1:0]      win_r [3];
  smp_t [COLS-1:0]      cur_row;
  logic                 row0;
  logic [1:0]           row_idx;
  logic                 accept;

  always_comb begin
    cur_row       = {in_sample_c3, in_sample_c2, in_sample_c1, in_sample_c0};
    row0          = in_first_row || (row_count_r == 2'd0);
    row_idx       = row0 ? 2'd0 : row_count_r;
    in_stall      = q_full;
    accept        = in_valid && !q_full;
    row_count_nxt = row_count_r;
    if (accept) begin
      row_count_nxt = (row_idx == LAST_ROW) ? 2'd0 : row_idx + 2'd1;
    end
    q_push.push       = accept && (row_idx == LAST_ROW);
    q_push.job.smp    = {cur_row, win_r[2], win_r[1], win_r[0]};
    q_push.job.frac_x = held_frac_x_r;
    q_push.job.frac_y = held_frac_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= 2'd0;
      held_frac_x_r <= '0;
      held_frac_y_r <= '0;
    end else begin
      row_count_r <= row_count_nxt;
      if (accept && row0) begin
        held_frac_x_r <= in_frac_x;
        held_frac_y_r <= in_frac_y;
      end
    end
  end

  // Window rows carry no reset; each is written before it is read.
  always_ff @(posedge clk) begin
    if (accept && (row_idx != LAST_ROW)) begin
      win_r[row_idx] <= cur_row;
    end
  end

endmodule

### hdl/smb_queue.sv
// ----------------------------------------------------------------------------
// smb_queue: window queue
// A small first-in first-out store of complete windows between the front
// and the back end.
// ----------------------------------------------------------------------------
module smb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  smb_pkg::push_t q_push,
  output logic           q_full,
  input  logic           q_pop,
  output smb_pkg::job_t  q_job,
  output logic           q_empty
);
  import smb_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  job_t             ent_r [Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;

  always_comb begin
    q_full     = (cnt_r == (PW+1)'(Q_DEPTH));
    q_empty    = (cnt_r == '0);
    q_job      = ent_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_push.push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      ent_r[wr_ptr_r] <= q_push.job;
    end
  end

endmodule

### hdl/smb_back.sv
// ----------------------------------------------------------------------------
// smb_back: limited cubic evaluator
// Works one window at a time through a shared multiplier: weights, ten
// slope-limited cubics, the final average, rounding and clamp.
// ----------------------------------------------------------------------------
module smb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          sample_signed,
  input  logic          q_empty,
  input  smb_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [15:0]   out_interpolated,
  output logic          out_clamped
);
  import smb_pkg::*;

  localparam int RW = VW - VAL_FRAC;   // width of the rounded result
  localparam logic signed [RW-1:0] HI_S = RW'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [RW-1:0] LO_S = -HI_S - RW'(1);
  localparam logic signed [RW-1:0] HI_U = RW'((64'sd1 <<< SAMPLE_BITS) - 1);
  localparam logic signed [VW:0]   HALF = (VW+1)'(64'sd1 <<< VAL_FRAC);
  localparam logic [3:0] K_LAST = 4'd9;

  function automatic logic signed [VW-1:0] to_val(input smp_t raw, input logic sgn);
    return {{(VW-SAMPLE_BITS-VAL_FRAC){sgn & raw[SAMPLE_BITS-1]}}, raw,
            {VAL_FRAC{1'b0}}};
  endfunction

  // Opposite strict signs give zero, else the smaller magnitude, first on a tie.
  function automatic logic signed [VW-1:0] minmod(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic [VW-1:0] ma, mb;
    ma = a[VW-1] ? -a : a;
    mb = b[VW-1] ? -b : b;
    if ((a > 0 && b < 0) || (a < 0 && b > 0)) begin
      return '0;
    end
    return (mb < ma) ? b : a;
  endfunction

  bk_state_t state_r, state_nxt;
  logic [3:0] k_r, k_nxt;
  logic [1:0] t_r, t_nxt;
  logic       out_valid_r, out_valid_nxt;

  job_t                   job_r;
  logic [W_ONE:0]         x2_r;
  logic signed [WW-1:0]   ptx_r, wlx_r, wrx_r, pty_r, wly_r, wry_r;
  logic signed [WW-1:0]   wpt_r, wwl_r, wwr_r;
  logic signed [VW-1:0]   p1_r, d0_r, d1_r, d2_r;
  logic signed [VW-1:0]   lim1_r, cr1_r, lim2_r, cr2_r, s1_r, s2_r, acc_r;
  logic [VW-1:0]          mag_r [3];
  logic [WW-2:0]          wmag_r [3];
  logic                   neg_r [3];
  logic [63-W_ONE:0]      lo_r;
  logic signed [VW-1:0]   tmp1_r [4];
  logic signed [VW-1:0]   tmp2_r [4];
  logic signed [VW-1:0]   py_r, px_r;
  logic signed [VW:0]     sum_r;
  logic signed [RW-1:0]   rnd_r;
  logic [15:0]            out_interpolated_r;
  logic                   out_clamped_r;

  logic [W_ONE-1:0]       xq_x, xq_y;
  logic [31:0]            mul_a, mul_b;
  logic [63:0]            mul_p, mul_rnd, lo_sum;
  logic [W_ONE:0]         x3;
  logic signed [WW+1:0]   x2s, x3s, xqs, pt_w, wl_w, wr_w;
  logic signed [VW-1:0]   op [4];
  logic                   sel_x;
  logic [VW-1:0]          sel_mag;
  logic [WW-2:0]          sel_wmag;
  logic                   sel_neg;
  logic [VW+1:0]          m_full;
  logic signed [VW-1:0]   a_t [3];
  logic signed [WW-1:0]   w_t [3];
  logic signed [VW:0]     sh_pos, sh_neg;
  logic signed [RW-1:0]   rn_pos, rn_neg, r_clamp;
  logic                   clamp_hit;
  logic                   out_load;

  // Operand selection for one cubic: four rows in x, their results in y,
  // four columns in y, their results in x.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      op[j] = '0;
    end
    sel_x = 1'b1;
    case (k_r)
      4'd0, 4'd1, 4'd2, 4'd3: begin
        for (int j = 0; j < 4; j++) begin
          op[j] = to_val(job_r.smp[k_r[1:0]][j], sample_signed);
        end
      end
      4'd4: begin
        for (int j = 0; j < 4; j++) begin
          op[j] = tmp1_r[j];
        end
        sel_x = 1'b0;
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        for (int i = 0; i < 4; i++) begin
          op[i] = to_val(job_r.smp[i][2'(k_r - 4'd5)], sample_signed);
        end
        sel_x = 1'b0;
      end
      default: begin
        for (int j = 0; j < 4; j++) begin
          op[j] = tmp2_r[j];
        end
      end
    endcase
  end

  // Shared multiplier.
  always_comb begin
    xq_x = {job_r.frac_x, {(W_ONE-FRAC_BITS){1'b0}}};
    xq_y = {job_r.frac_y, {(W_ONE-FRAC_BITS){1'b0}}};
    case (t_r)
      2'd0:    begin sel_mag = mag_r[0]; sel_wmag = wmag_r[0]; sel_neg = neg_r[0]; end
      2'd1:    begin sel_mag = mag_r[1]; sel_wmag = wmag_r[1]; sel_neg = neg_r[1]; end
      default: begin sel_mag = mag_r[2]; sel_wmag = wmag_r[2]; sel_neg = neg_r[2]; end
    endcase
    case (state_r)
      BK_WX2:  begin mul_a = 32'(xq_x); mul_b = 32'(xq_x); end
      BK_WX3:  begin mul_a = 32'(x2_r); mul_b = 32'(xq_x); end
      BK_WY2:  begin mul_a = 32'(xq_y); mul_b = 32'(xq_y); end
      BK_WY3:  begin mul_a = 32'(x2_r); mul_b = 32'(xq_y); end
      BK_ML:   begin mul_a = sel_mag[31:0]; mul_b = 32'(sel_wmag); end
      BK_MH:   begin mul_a = 32'(sel_mag[VW-1:32]); mul_b = 32'(sel_wmag); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p   = mul_a * mul_b;
    mul_rnd = mul_p + (64'd1 << (W_ONE-1));
    x3      = mul_rnd[2*W_ONE:W_ONE];
    x2s     = (WW+2)'(x2_r);
    x3s     = (WW+2)'(x3);
    xqs     = (state_r == BK_WX3) ? (WW+2)'(xq_x) : (WW+2)'(xq_y);
    pt_w    = x2s + x2s + x2s - x3s - x3s;
    wl_w    = x3s - x2s - x2s + xqs;
    wr_w    = x3s - x2s;
    // Point terms round at 2^-30, slope terms at 2^-31.
    lo_sum  = mul_p + ((t_r == 2'd0) ? (64'd1 << (W_ONE-1)) : (64'd1 << W_ONE));
    m_full  = (t_r == 2'd0) ? ((VW+2)'(mul_p) << (32-W_ONE)) + (VW+2)'(lo_r)
                            : ((VW+2)'(mul_p) << (31-W_ONE)) + (VW+2)'(lo_r);
    a_t[0] = d1_r;  w_t[0] = wpt_r;
    a_t[1] = s1_r;  w_t[1] = wwl_r;
    a_t[2] = s2_r;  w_t[2] = wwr_r;
  end

  // Final rounding and clamp.
  always_comb begin
    sh_pos = (sum_r + HALF) >>> (VAL_FRAC + 1);
    sh_neg = (HALF - sum_r) >>> (VAL_FRAC + 1);
    rn_pos = sh_pos[RW-1:0];
    rn_neg = sh_neg[RW-1:0];
    r_clamp   = rnd_r;
    clamp_hit = 1'b0;
    if (sample_signed) begin
      if (rnd_r > HI_S) begin
        r_clamp = HI_S; clamp_hit = 1'b1;
      end else if (rnd_r < LO_S) begin
        r_clamp = LO_S; clamp_hit = 1'b1;
      end
    end else begin
      if (rnd_r > HI_U) begin
        r_clamp = HI_U; clamp_hit = 1'b1;
      end else if (rnd_r < 0) begin
        r_clamp = '0; clamp_hit = 1'b1;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_WX2;
        end
      end
      BK_WX2:   state_nxt = BK_WX3;
      BK_WX3:   state_nxt = BK_WY2;
      BK_WY2:   state_nxt = BK_WY3;
      BK_WY3: begin
        state_nxt = BK_LOAD;
        k_nxt     = 4'd0;
      end
      BK_LOAD:  state_nxt = BK_LIM;
      BK_LIM:   state_nxt = BK_SLOPE;
      BK_SLOPE: state_nxt = BK_ABS;
      BK_ABS: begin
        state_nxt = BK_ML;
        t_nxt     = 2'd0;
      end
      BK_ML:    state_nxt = BK_MH;
      BK_MH: begin
        if (t_r == 2'd2) begin
          state_nxt = BK_STORE;
        end else begin
          state_nxt = BK_ML;
          t_nxt     = t_r + 2'd1;
        end
      end
      BK_STORE: begin
        if (k_r == K_LAST) begin
          state_nxt = BK_FINAL;
        end else begin
          state_nxt = BK_LOAD;
          k_nxt     = k_r + 4'd1;
        end
      end
      BK_FINAL: state_nxt = BK_RND;
      BK_RND:   state_nxt = BK_OUT;
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      k_r         <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      t_r         <= t_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          job_r <= q_job;
        end
      end
      BK_WX2, BK_WY2: x2_r <= mul_rnd[2*W_ONE:W_ONE];
      BK_WX3: begin
        ptx_r <= pt_w[WW-1:0];
        wlx_r <= wl_w[WW-1:0];
        wrx_r <= wr_w[WW-1:0];
      end
      BK_WY3: begin
        pty_r <= pt_w[WW-1:0];
        wly_r <= wl_w[WW-1:0];
        wry_r <= wr_w[WW-1:0];
      end
      BK_LOAD: begin
        p1_r  <= op[1];
        d0_r  <= op[1] - op[0];
        d1_r  <= op[2] - op[1];
        d2_r  <= op[3] - op[2];
        wpt_r <= sel_x ? ptx_r : pty_r;
        wwl_r <= sel_x ? wlx_r : wly_r;
        wwr_r <= sel_x ? wrx_r : wry_r;
      end
      BK_LIM: begin
        lim1_r <= (minmod(d1_r, d0_r) <<< 2) + (minmod(d1_r, d0_r) <<< 1);
        cr1_r  <= d1_r + d0_r;
        lim2_r <= (minmod(d1_r, d2_r) <<< 2) + (minmod(d1_r, d2_r) <<< 1);
        cr2_r  <= d1_r + d2_r;
      end
      BK_SLOPE: begin
        s1_r  <= minmod(lim1_r, cr1_r);
        s2_r  <= minmod(lim2_r, cr2_r);
        acc_r <= p1_r;
      end
      BK_ABS: begin
        for (int n = 0; n < 3; n++) begin
          mag_r[n]  <= a_t[n][VW-1] ? -a_t[n] : a_t[n];
          wmag_r[n] <= w_t[n][WW-1] ? 31'(-w_t[n]) : w_t[n][WW-2:0];
          neg_r[n]  <= a_t[n][VW-1] != w_t[n][WW-1];
        end
      end
      BK_ML: begin
        lo_r <= (t_r == 2'd0) ? lo_sum[63:W_ONE] : (64-W_ONE)'(lo_sum[63:W_ONE+1]);
      end
      BK_MH: begin
        acc_r <= sel_neg ? acc_r - m_full[VW-1:0] : acc_r + m_full[VW-1:0];
      end
      BK_STORE: begin
        case (k_r)
          4'd0, 4'd1, 4'd2, 4'd3: tmp1_r[k_r[1:0]] <= acc_r;
          4'd4:                   py_r <= acc_r;
          4'd5, 4'd6, 4'd7, 4'd8: tmp2_r[2'(k_r - 4'd5)] <= acc_r;
          default:                px_r <= acc_r;
        endcase
      end
      BK_FINAL: sum_r <= {py_r[VW-1], py_r} + {px_r[VW-1], px_r};
      BK_RND:   rnd_r <= (sample_signed && sum_r < 0) ? -rn_neg : rn_pos;
      default: begin
      end
    endcase
    if (out_load) begin
      out_interpolated_r <= r_clamp[15:0];
      out_clamped_r      <= clamp_hit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interpolated = out_interpolated_r;
  assign out_clamped      = out_clamped_r;

endmodule

### hdl/symmetrized_monotone_bicubic.sv
// ----------------------------------------------------------------------------
// symmetrized_monotone_bicubic: monotone bicubic resampler core
// Collects a 4x4 window as four row words and returns one limited, symmetrized
// bicubic sample per window.
// ----------------------------------------------------------------------------
// A window arrives as four row words; the fourth one completes the window and
// yields exactly one result word, the first three yield none. A row word with
// in_first_row set always starts a new window and latches the offsets. The
// front end accepts a row word every cycle while the two-deep window queue has
// room. The back end works on one window at a time: it forms the x and y
// Hermite weights on the multiplier, runs ten slope-limited cubic evaluations
// and then averages, rounds and clamps. Its pace is set by the single shared
// 32x32 multiplier, which each weight product visits twice (low and high half
// of the operand). The front end keeps taking row words while the back end
// evaluates a window; short bursts of up to two extra windows are absorbed by
// the queue and the output register. cfg_wr_data selects unsigned (0) or two's
// complement (1) samples and may only be written while the block is idle.
module symmetrized_monotone_bicubic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_sample_c0,
  input  logic [15:0]         in_sample_c1,
  input  logic [15:0]         in_sample_c2,
  input  logic [15:0]         in_sample_c3,
  input  logic [15:0]         in_frac_x,
  input  logic [15:0]         in_frac_y,
  input  logic                in_first_row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_interpolated,
  output logic                out_clamped
);
  import smb_pkg::*;

  logic  sample_signed_r;
  push_t q_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  job_t  q_job;

  // The sample format register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_signed_r <= 1'b0;
    end else if (cfg_wr_en) begin
      sample_signed_r <= cfg_wr_data;
    end
  end

  // The front end gathers rows and emits one word per complete window.
  smb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_c0 (in_sample_c0),
    .in_sample_c1 (in_sample_c1),
    .in_sample_c2 (in_sample_c2),
    .in_sample_c3 (in_sample_c3),
    .in_frac_x    (in_frac_x),
    .in_frac_y    (in_frac_y),
    .in_first_row (in_first_row),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  // Windows wait here so the row side and the evaluator stall independently.
  smb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_job   (q_job),
    .q_empty (q_empty)
  );

  // The evaluator drives the output register directly.
  smb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .sample_signed    (sample_signed_r),
    .q_empty          (q_empty),
    .q_job            (q_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_interpolated (out_interpolated),
    .out_clamped      (out_clamped)
  );

`ifndef SYNTH
  // A window is only queued when its last row word is actually taken.
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> (in_valid && !in_stall))
    else $error("window queued without an accepted row word");

  // The evaluator never pops an empty queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("window queue popped while empty");

  // An unsigned clamped result sits on one of the range limits.
  a_clamp_unsigned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamped && !sample_signed_r) |->
      (out_interpolated == 16'h0000 || out_interpolated == 16'hFFFF))
    else $error("unsigned clamp outside the range limits");

  // A signed clamped result sits on one of the range limits.
  a_clamp_signed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamped && sample_signed_r) |->
      (out_interpolated == 16'h7FFF || out_interpolated == 16'h8000))
    else $error("signed clamp outside the range limits");
`endif

endmodule
